>>> hdl/per_class_response_rate_limiter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-class response rate limiter
// ----------------------------------------------------------------------------
`ifndef PER_CLASS_RESPONSE_RATE_LIMITER_TOP_MACROS_SVH
`define PER_CLASS_RESPONSE_RATE_LIMITER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PCRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PCRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pcrl_pkg.sv
// ----------------------------------------------------------------------------
// pcrl_pkg
// Types and constants shared by the per-class response rate limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcrl_pkg;

    localparam int NUM_CLASSES_DEF = 5;

    localparam int CLASS_W = 3;
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 32;
    localparam int REG_W   = 20;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'b1;

    localparam logic [REG_W-1:0] PACKET_LIMIT_RST     = 20'd200;
    localparam logic [REG_W-1:0] TICKS_PER_SECOND_RST = 20'd100;

    typedef struct packed {
        logic [CLASS_W-1:0] class_index;
        logic [TICK_W-1:0]  current_tick;
    } t_req;

    typedef struct packed {
        logic               allowed;
        logic [COUNT_W-1:0] window_count;
    } t_resp;

endpackage

`default_nettype wire

>>> hdl/per_class_response_rate_limiter_top.sv
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per clock while the output is not stalled; the per-class window
//   update is a single subtract, compare and increment between the two registers.
// A stalled output holds one result while one more item waits in the input register.
// Reset (synchronous, active low) clears all window starts and counts and loads
//   packet_limit = 200 and ticks_per_second = 100.
// ----------------------------------------------------------------------------
// per_class_response_rate_limiter_top
// Fixed-window rate limiter with one window start and packet count per class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_class_response_rate_limiter_top
    import pcrl_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_req                 i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_resp                     o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [CLASS_W:0] NUM_CLASSES_V = (CLASS_W + 1)'(NUM_CLASSES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    logic [REG_W-1:0] r_packet_limit;
    logic [REG_W-1:0] r_ticks_per_second;

    logic [TICK_W-1:0]  r_window_start   [NUM_CLASSES];
    logic [COUNT_W-1:0] r_window_packets [NUM_CLASSES];

    logic  r_in_valid;
    t_req  r_in;
    logic  r_out_valid;
    t_resp r_out;

    logic               advance;
    logic               in_range;
    logic               bypass;
    logic [IDX_W-1:0]   cls_idx;
    logic [TICK_W-1:0]  elapsed;
    logic               restart;
    logic [COUNT_W-1:0] base_count;
    logic [COUNT_W-1:0] n_count;
    t_resp              n_out;

    // Move the held item into the result register when it is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        in_range   = {1'b0, r_in.class_index} < NUM_CLASSES_V;
        bypass     = (r_packet_limit == '0) || !in_range;
        cls_idx    = r_in.class_index[IDX_W-1:0];
        elapsed    = '0;
        restart    = 1'b0;
        base_count = '0;
        n_count    = '0;
        if (in_range) begin
            elapsed    = r_in.current_tick - r_window_start[cls_idx];
            restart    = elapsed > {{(TICK_W - REG_W){1'b0}}, r_ticks_per_second};
            base_count = restart ? '0 : r_window_packets[cls_idx];
            // Saturate at the top of the counter
            n_count    = (base_count == COUNT_MAX) ? base_count : base_count + 1'b1;
        end
        if (bypass) begin
            n_out.allowed      = 1'b1;
            n_out.window_count = '0;
        end else begin
            n_out.allowed      = n_count <= {{(COUNT_W - REG_W){1'b0}}, r_packet_limit};
            n_out.window_count = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_limit     <= PACKET_LIMIT_RST;
            r_ticks_per_second <= TICKS_PER_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PACKET_LIMIT:     r_packet_limit     <= i_cfg_wdata;
                CFG_TICKS_PER_SECOND: r_ticks_per_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_window_start[k]   <= '0;
                r_window_packets[k] <= '0;
            end
        end else if (advance && !bypass) begin
            if (restart) begin
                r_window_start[cls_idx] <= r_in.current_tick;
            end
            r_window_packets[cls_idx] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pcrl_checker.sv
// ----------------------------------------------------------------------------
// pcrl_checker
// Port-level checks for the per-class response rate limiter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "per_class_response_rate_limiter_top_macros.svh"

module pcrl_checker
    import pcrl_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  o_in_ready,
    input wire logic  o_out_valid,
    input wire logic  i_out_ready,
    input wire t_resp o_out_data
);

    // Hold a stalled result
    `PCRL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "stalled result changed or dropped")

    // A denied item always carries a nonzero count
    `PCRL_ASSERT_NOW(a_deny_count, i_clk, i_rst_n, o_out_valid && !o_out_data.allowed,
        o_out_data.window_count != '0, "denied item with zero window count")

    // With no result pending the block must take an item
    `PCRL_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !o_out_valid,
        o_in_ready, "input stalled while output empty")

endmodule

bind per_class_response_rate_limiter_top pcrl_checker u_pcrl_checker (.*);

`default_nettype wire
